// ===== rtl/core/wbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted backend scheduler package
// Payload types, operation and register codes, and field selection helpers
// shared by the scheduler, its checker, the pick checker and the testbench.
// ----------------------------------------------------------------------------
package wbs_pkg;

   // Width of the register index and data on the configuration port.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   // Operation codes of an input item.
   localparam logic [1:0] OP_SCHEDULE = 2'd0;
   localparam logic [1:0] OP_OPEN     = 2'd1;
   localparam logic [1:0] OP_CLOSE    = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POLICY_MODE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BACKEND_CNT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WEIGHTS     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRIORITIES  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMITS_LOW  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMITS_HIGH = 3'd5;

   // Policy selection.
   localparam logic MODE_ROUND_ROBIN = 1'b0;
   localparam logic MODE_LEAST_CONN  = 1'b1;

   // One request item.
   typedef struct packed {
      logic [1:0] opcode;
      logic [2:0] backend_index;
      logic [7:0] up_mask;
      logic [3:0] service_priority;
   } req_type;

   // One result item.
   typedef struct packed {
      logic       found;
      logic [2:0] chosen_backend;
   } rsp_type;

   // 8-bit weight of a backend.
   function automatic logic [7:0] weight_of(input logic [63:0] weights, input logic [2:0] b);
      return weights[b*8 +: 8];
   endfunction

   // 4-bit priority of a backend.
   function automatic logic [3:0] prio_of(input logic [31:0] prios, input logic [2:0] b);
      return prios[b*4 +: 4];
   endfunction

   // 16-bit connection limit of a backend, split over two registers.
   function automatic logic [15:0] limit_of(input logic [63:0] lim_lo, input logic [63:0] lim_hi,
                                             input logic [2:0] b);
      logic [15:0] lim;
      if (b[2]) begin
         lim = lim_hi[b[1:0]*16 +: 16];
      end else begin
         lim = lim_lo[b[1:0]*16 +: 16];
      end
      return lim;
   endfunction

endpackage

// ===== rtl/core/wbs_conn_store.sv =====
// ----------------------------------------------------------------------------
// Connection count store
// One-write, one-read synchronous memory of per-backend connection counts
// with a registered read. A valid bit per entry makes unwritten entries
// read as zero right after reset.
// ----------------------------------------------------------------------------
module wbs_conn_store #(
   parameter int DEPTH  = 8,
   parameter int IDX_W  = 3,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [DEPTH-1:0]  vld_in;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_vld_ff;

   // Entry valid bits: set on the first write, cleared by reset.
   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Memory write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; the valid bit travels with the data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      rd_vld_ff  <= vld_ff[rd_addr];
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ===== rtl/core/weighted_backend_scheduler.sv =====
// ----------------------------------------------------------------------------
// Weighted backend scheduler
// Picks a backend per schedule request by weighted round robin or weighted
// least connections, and keeps saturating per-backend connection counts
// updated by open and close events.
//
//   channel | ports             | direction | carries
//   --------+-------------------+-----------+-------------------------------
//   request | req_valid/ready   | in        | req_type: opcode, index, mask
//   result  | rsp_valid/ready   | out       | rsp_type: found, chosen index
//   config  | csr_valid/ready   | in        | register index and 64-bit data
//
// A schedule request examines one backend per cycle through the single read
// port of the connection count memory. A round-robin request scans at most
// two passes over the backends in use, a least-connections request one pass;
// an open or close event reads and updates one count.
// Reset is synchronous; counts read as zero at once through per-entry valid
// bits, so no clearing pass runs after reset.
// A finished result waits in the output register; the next item is taken
// meanwhile and holds in its final cycle only if that register is still full.
// ----------------------------------------------------------------------------
module weighted_backend_scheduler #(
   parameter int NUM_BACKENDS    = 8,
   parameter int CONN_COUNT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  wbs_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output wbs_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wbs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [wbs_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int IDX_W  = $clog2(NUM_BACKENDS);
   localparam int STEP_W = $clog2(2 * NUM_BACKENDS);
   localparam int LIM_W  = (CONN_COUNT_BITS > 16) ? CONN_COUNT_BITS : 16;
   localparam int PROD_W = CONN_COUNT_BITS + 8;
   localparam logic [3:0]                 NUM_B4   = 4'(NUM_BACKENDS);
   localparam logic [CONN_COUNT_BITS-1:0] CONN_MAX = '1;

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RR    = 3'd1;
   localparam logic [2:0] S_LC    = 3'd2;
   localparam logic [2:0] S_EVENT = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   // Configuration registers.
   logic        mode_ff;
   logic [3:0]  count_cfg_ff;
   logic [63:0] weights_ff;
   logic [31:0] prios_ff;
   logic [63:0] lim_lo_ff;
   logic [63:0] lim_hi_ff;

   // Sequencer and item registers.
   logic [2:0]                 state_ff, state_in;
   logic [1:0]                 op_ff, op_in;
   logic                       idx_ok_ff, idx_ok_in;
   logic [7:0]                 up_ff, up_in;
   logic [3:0]                 svc_prio_ff, svc_prio_in;
   logic [IDX_W-1:0]           cur_ff, cur_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       have_ff, have_in;
   logic [IDX_W-1:0]           sel_ff, sel_in;
   logic [CONN_COUNT_BITS-1:0] sel_conns_ff, sel_conns_in;
   logic                       res_found_ff, res_found_in;
   logic [2:0]                 res_chosen_ff, res_chosen_in;

   // Round-robin state.
   logic [IDX_W-1:0] rr_pos_ff, rr_pos_in;
   logic [8:0]       use_ff, use_in;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   wbs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Memory port.
   logic                       wr_en;
   logic [CONN_COUNT_BITS-1:0] wr_data;
   logic [IDX_W-1:0]           rd_addr;
   logic [CONN_COUNT_BITS-1:0] conns;

   // Derived values.
   logic [3:0]        count_eff;
   logic [IDX_W-1:0]  rr_start;
   logic [2:0]        cur_num;
   logic [7:0]        weight_cur;
   logic [7:0]        weight_sel;
   logic [15:0]       limit_cur;
   logic              elig;
   logic              cur_at_end;
   logic [IDX_W-1:0]  next_b;
   logic [8:0]        use_inc;
   logic              rr_pick;
   logic [4:0]        last_step;
   logic              rr_last;
   logic [PROD_W-1:0] prod_new;
   logic [PROD_W-1:0] prod_sel;
   logic              lc_take;
   logic              rsp_load;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= wbs_pkg::MODE_ROUND_ROBIN;
         count_cfg_ff <= 4'd1;
         weights_ff   <= 64'h0101_0101_0101_0101;
         prios_ff     <= '0;
         lim_lo_ff    <= '0;
         lim_hi_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            wbs_pkg::CSR_POLICY_MODE: mode_ff      <= csr_data[0];
            wbs_pkg::CSR_BACKEND_CNT: count_cfg_ff <= csr_data[3:0];
            wbs_pkg::CSR_WEIGHTS:     weights_ff   <= csr_data;
            wbs_pkg::CSR_PRIORITIES:  prios_ff     <= csr_data[31:0];
            wbs_pkg::CSR_LIMITS_LOW:  lim_lo_ff    <= csr_data;
            wbs_pkg::CSR_LIMITS_HIGH: lim_hi_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Backend count in use and the round-robin start position.
   assign count_eff = (count_cfg_ff > NUM_B4) ? NUM_B4 : count_cfg_ff;
   assign rr_start  = (4'(rr_pos_ff) < count_eff) ? rr_pos_ff : '0;

   // Eligibility of the backend whose count arrives from memory this cycle.
   assign cur_num    = 3'(cur_ff);
   assign weight_cur = wbs_pkg::weight_of(weights_ff, cur_num);
   assign weight_sel = wbs_pkg::weight_of(weights_ff, 3'(sel_ff));
   assign limit_cur  = wbs_pkg::limit_of(lim_lo_ff, lim_hi_ff, cur_num);
   assign elig = up_ff[cur_num]
              && (wbs_pkg::prio_of(prios_ff, cur_num) <= svc_prio_ff)
              && !((limit_cur != 16'd0) && (LIM_W'(limit_cur) < LIM_W'(conns)));

   // Position stepping, wrapping at the backend count.
   assign cur_at_end = (4'(cur_ff) + 4'd1) >= count_eff;
   assign next_b     = cur_at_end ? '0 : cur_ff + 1'b1;

   // Round robin: use counter against the weight, two passes at most.
   assign use_inc   = use_ff + 9'd1;
   assign rr_pick   = elig && (use_inc <= {1'b0, weight_cur});
   assign last_step = {count_eff, 1'b0} - 5'd1;
   assign rr_last   = (5'(step_ff) == last_step);

   // Least connections: cross-multiplied ratio compare.
   assign prod_new = PROD_W'(conns) * PROD_W'(weight_sel);
   assign prod_sel = PROD_W'(sel_conns_ff) * PROD_W'(weight_cur);
   assign lc_take  = elig && (!have_ff || (prod_new < prod_sel));

   // Event update with saturation at both ends.
   always_comb begin
      wr_en   = 1'b0;
      wr_data = conns + 1'b1;
      if (state_ff == S_EVENT && idx_ok_ff) begin
         if (op_ff == wbs_pkg::OP_OPEN) begin
            wr_en = (conns != CONN_MAX);
         end else begin
            wr_en   = (conns != '0);
            wr_data = conns - 1'b1;
         end
      end
   end

   // Read address: taken from the request at transfer, then the next backend.
   always_comb begin
      rd_addr = cur_ff;
      if (state_ff == S_IDLE) begin
         if (req_data.opcode == wbs_pkg::OP_SCHEDULE) begin
            rd_addr = (mode_ff == wbs_pkg::MODE_ROUND_ROBIN && count_eff > 4'd1) ?
                      rr_start : '0;
         end else begin
            rd_addr = IDX_W'(req_data.backend_index);
         end
      end else if (state_ff == S_RR || state_ff == S_LC) begin
         rd_addr = next_b;
      end
   end

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_ok_in     = idx_ok_ff;
      up_in         = up_ff;
      svc_prio_in   = svc_prio_ff;
      cur_in        = cur_ff;
      step_in       = step_ff;
      have_in       = have_ff;
      sel_in        = sel_ff;
      sel_conns_in  = sel_conns_ff;
      res_found_in  = res_found_ff;
      res_chosen_in = res_chosen_ff;
      rr_pos_in     = rr_pos_ff;
      use_in        = use_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_data.opcode;
               idx_ok_in     = ({1'b0, req_data.backend_index} < NUM_B4);
               up_in         = req_data.up_mask;
               svc_prio_in   = req_data.service_priority;
               cur_in        = IDX_W'(req_data.backend_index);
               step_in       = '0;
               have_in       = 1'b0;
               sel_in        = '0;
               sel_conns_in  = '0;
               res_found_in  = 1'b0;
               res_chosen_in = 3'd0;
               case (req_data.opcode) inside
                  wbs_pkg::OP_SCHEDULE: begin
                     if (count_eff == 4'd0) begin
                        state_in = S_DONE;
                     end else if (count_eff == 4'd1 ||
                                  mode_ff == wbs_pkg::MODE_LEAST_CONN) begin
                        cur_in   = '0;
                        state_in = S_LC;
                     end else begin
                        cur_in   = rr_start;
                        state_in = S_RR;
                     end
                  end
                  wbs_pkg::OP_OPEN, wbs_pkg::OP_CLOSE: begin
                     state_in = S_EVENT;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_RR: begin
            if (rr_pick) begin
               rr_pos_in     = cur_ff;
               use_in        = use_inc;
               res_found_in  = 1'b1;
               res_chosen_in = cur_num;
               state_in      = S_DONE;
            end else begin
               use_in    = '0;
               rr_pos_in = next_b;
               if (rr_last) begin
                  state_in = S_DONE;
               end else begin
                  cur_in  = next_b;
                  step_in = step_ff + 1'b1;
               end
            end
         end
         S_LC: begin
            if (lc_take) begin
               have_in      = 1'b1;
               sel_in       = cur_ff;
               sel_conns_in = conns;
            end
            if (cur_at_end) begin
               res_found_in  = have_ff || lc_take;
               res_chosen_in = lc_take ? cur_num : (have_ff ? 3'(sel_ff) : 3'd0);
               state_in      = S_DONE;
            end else begin
               cur_in = next_b;
            end
         end
         S_EVENT: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.found           = res_found_ff;
         rsp_data_in.chosen_backend  = res_found_ff ? res_chosen_ff : 3'd0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rr_pos_ff    <= '0;
         use_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rr_pos_ff    <= rr_pos_in;
         use_ff       <= use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item payload and scan registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ok_ff     <= idx_ok_in;
      up_ff         <= up_in;
      svc_prio_ff   <= svc_prio_in;
      cur_ff        <= cur_in;
      step_ff       <= step_in;
      have_ff       <= have_in;
      sel_ff        <= sel_in;
      sel_conns_ff  <= sel_conns_in;
      res_found_ff  <= res_found_in;
      res_chosen_ff <= res_chosen_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Connection count memory.
   wbs_conn_store #(
      .DEPTH  (NUM_BACKENDS),
      .IDX_W  (IDX_W),
      .DATA_W (CONN_COUNT_BITS)
   ) u_conn_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (cur_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (conns)
   );

endmodule

// ===== rtl/core/wbs_checker.sv =====
// ----------------------------------------------------------------------------
// Weighted backend scheduler checker
// Port-level assertions on the request and result channels, bound to the
// top level.
// ----------------------------------------------------------------------------
module wbs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input wbs_pkg::rsp_type rsp_data
);

   logic [1:0] pend_ff, pend_in;

   // Items taken but whose result has not yet been transferred.
   always_comb begin
      pend_in = pend_ff;
      if (req_valid && req_ready && !(rsp_valid && rsp_ready)) begin
         pend_in = pend_ff + 2'd1;
      end else if (!(req_valid && req_ready) && rsp_valid && rsp_ready) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // No backend is reported when nothing was found.
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.chosen_backend == 3'd0)
      else $error("chosen backend set without a find");

   // One item at a time: the request side closes after each transfer.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in work");

   // Every result belongs to an item already taken.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without a pending item");

   // At most one item in work and one result waiting.
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many items outstanding");

endmodule

bind weighted_backend_scheduler wbs_checker u_wbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== sim/wbs_pick_checker.sv =====
// ----------------------------------------------------------------------------
// Weighted backend scheduler pick checker
// Watches the request, result and register channels of the scheduler, keeps
// its own copy of the registers, the round-robin state and the connection
// counts, predicts the result of every request transfer and compares each
// result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module wbs_pick_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  wbs_pkg::req_type                     req_data,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  wbs_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [wbs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [wbs_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output int                                   mismatch_count,
   output int                                   picks_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import wbs_pkg::*;

   localparam int          BACKENDS  = 8;
   localparam logic [15:0] CONN_CEIL = 16'hFFFF;

   // Shadow copy of the registers.
   logic        mode;
   logic [3:0]  count_cfg;
   logic [63:0] weights;
   logic [31:0] prios;
   logic [63:0] limits_lo;
   logic [63:0] limits_hi;

   // Shadow copy of the scheduling state.
   logic [3:0]  rr_pos;
   logic [8:0]  rr_uses;
   logic [15:0] conns [BACKENDS];

   // Predicted results, oldest first.
   rsp_type     expected_picks [$];

   initial begin
      mismatch_count = 0;
      picks_pending  = 0;
   end

   function automatic logic [7:0] weight_at(input int b);
      return weights[b*8 +: 8];
   endfunction

   // A backend is eligible when it is up, within its limit and not above the level.
   function automatic logic eligible_now(input int b, input logic [7:0] up,
                                         input logic [3:0] level);
      logic [15:0] cap;
      cap = (b < 4) ? limits_lo[b*16 +: 16] : limits_hi[(b-4)*16 +: 16];
      if (cap != 16'd0 && cap < conns[b]) begin
         return 1'b0;
      end
      if (!up[b]) begin
         return 1'b0;
      end
      return prios[b*4 +: 4] <= level;
   endfunction

   // Weighted round robin: walk from the kept position, give up after two laps.
   function automatic rsp_type round_robin_pick(input int n, input logic [7:0] up,
                                                input logic [3:0] level);
      rsp_type pick;
      int      pos;
      int      first;
      int      laps;
      int      b;
      logic    started;
      logic    done;
      pick    = '0;
      pos     = (rr_pos < n) ? int'(rr_pos) : 0;
      first   = pos;
      laps    = 0;
      started = 1'b0;
      done    = 1'b0;
      while (!done) begin
         b = pos;
         if (started && b == first) begin
            laps++;
         end
         started = 1'b1;
         if (laps >= 2) begin
            done = 1'b1;
         end else begin
            if (eligible_now(b, up, level)) begin
               rr_uses = rr_uses + 9'd1;
               if (rr_uses <= {1'b0, weight_at(b)}) begin
                  rr_pos              = 4'(b);
                  pick.found          = 1'b1;
                  pick.chosen_backend = 3'(b);
                  done                = 1'b1;
               end
            end
            if (!done) begin
               rr_uses = '0;
               pos     = (b + 1 >= n) ? 0 : b + 1;
               rr_pos  = 4'(pos);
            end
         end
      end
      return pick;
   endfunction

   // Weighted least connections by cross multiplication; the earlier backend wins ties.
   function automatic rsp_type least_conn_pick(input int n, input logic [7:0] up,
                                               input logic [3:0] level);
      rsp_type     pick;
      logic        have;
      int          sel;
      logic [31:0] sel_load;
      logic [31:0] lhs;
      logic [31:0] rhs;
      have     = 1'b0;
      sel      = 0;
      sel_load = '0;
      for (int b = 0; b < n; b++) begin
         if (eligible_now(b, up, level)) begin
            lhs = 32'(conns[b]) * 32'(weight_at(sel));
            rhs = sel_load * 32'(weight_at(b));
            if (!have || lhs < rhs) begin
               have     = 1'b1;
               sel      = b;
               sel_load = 32'(conns[b]);
            end
         end
      end
      pick.found          = have;
      pick.chosen_backend = have ? 3'(sel) : 3'd0;
      return pick;
   endfunction

   // Result of one request, updating the shadow state on the way.
   function automatic rsp_type next_pick(input req_type item);
      rsp_type pick;
      int      n;
      pick = '0;
      case (item.opcode)
         OP_OPEN: begin
            if (conns[item.backend_index] != CONN_CEIL) begin
               conns[item.backend_index] = conns[item.backend_index] + 16'd1;
            end
         end
         OP_CLOSE: begin
            if (conns[item.backend_index] != 16'd0) begin
               conns[item.backend_index] = conns[item.backend_index] - 16'd1;
            end
         end
         OP_SCHEDULE: begin
            n = (count_cfg > 4'd8) ? 8 : int'(count_cfg);
            if (n == 1) begin
               pick.found = eligible_now(0, item.up_mask, item.service_priority);
            end else if (n > 1) begin
               if (mode == MODE_ROUND_ROBIN) begin
                  pick = round_robin_pick(n, item.up_mask, item.service_priority);
               end else begin
                  pick = least_conn_pick(n, item.up_mask, item.service_priority);
               end
            end
         end
         default: begin
         end
      endcase
      return pick;
   endfunction

   // Result transfers are checked before the request transfer of the same edge is predicted.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         mode      = MODE_ROUND_ROBIN;
         count_cfg = 4'd1;
         weights   = 64'h0101_0101_0101_0101;
         prios     = '0;
         limits_lo = '0;
         limits_hi = '0;
         rr_pos    = '0;
         rr_uses   = '0;
         for (int b = 0; b < BACKENDS; b++) begin
            conns[b] = '0;
         end
         expected_picks.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_picks.size() == 0) begin
               $error("result transfer with nothing expected: found %0d chosen_backend %0d",
                      rsp_data.found, rsp_data.chosen_backend);
               mismatch_count++;
            end else begin
               want = expected_picks.pop_front();
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_data.found);
                  mismatch_count++;
               end
               if (rsp_data.chosen_backend !== want.chosen_backend) begin
                  $error("chosen_backend: expected %0d, actual %0d",
                         want.chosen_backend, rsp_data.chosen_backend);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POLICY_MODE: mode      = csr_data[0];
               CSR_BACKEND_CNT: count_cfg = csr_data[3:0];
               CSR_WEIGHTS:     weights   = csr_data;
               CSR_PRIORITIES:  prios     = csr_data[31:0];
               CSR_LIMITS_LOW:  limits_lo = csr_data;
               CSR_LIMITS_HIGH: limits_hi = csr_data;
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            expected_picks.push_back(next_pick(req_data));
         end
      end
      picks_pending = expected_picks.size();
   end

endmodule

// ===== sim/tb_weighted_backend_scheduler.sv =====
// ----------------------------------------------------------------------------
// Weighted backend scheduler testbench
// Drives directed and random requests and register settings into the
// scheduler under several idle and stall patterns, runs one backend's
// connection count up and back down past zero, and lets the pick checker
// judge every result transfer.
// ----------------------------------------------------------------------------
module tb_weighted_backend_scheduler;
   timeunit 1ns;
   timeprecision 1ps;

   import wbs_pkg::*;

   localparam logic [1:0]                OP_UNUSED      = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO   = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI   = 3'd7;
   localparam int                        SETTLE_CYCLES  = 40;
   localparam int                        WATCHDOG_LIMIT = 2000;
   localparam int                        COUNT_RUN      = 24;
   localparam int                        RANDOM_BLOCKS  = 8;
   localparam int                        BLOCK_ITEMS    = 200;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_type                   rsp_data;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   int                        mismatch_count;
   int                        picks_pending;
   int                        idle_pct;
   int                        stall_pct;
   int                        quiet_cycles = 0;

   weighted_backend_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   wbs_pick_checker pick_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .picks_pending  (picks_pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // The run ends if no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One register write, after which the channel is left idle before the task returns.
   task automatic set_reg(input logic [CSR_INDEX_BITS-1:0] index,
                          input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Hold the sender until every predicted result has come back.
   task automatic drain_picks();
      req_valid <= 1'b0;
      @(posedge clock);
      while (picks_pending != 0) begin
         @(posedge clock);
      end
   endtask

   // Drain, then give the block time to finish work that has no result left.
   task automatic settle();
      drain_picks();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One request transfer, preceded by random idle cycles of the sender.
   task automatic issue(input logic [1:0] op, input logic [2:0] index,
                        input logic [7:0] up, input logic [3:0] level);
      req_type item;
      item.opcode           = op;
      item.backend_index    = index;
      item.up_mask          = up;
      item.service_priority = level;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // Random request: mostly schedules, open events slightly ahead of closes.
   task automatic random_item();
      logic [1:0] op;
      logic [7:0] up;
      int         r;
      r  = $urandom_range(99);
      op = (r < 55) ? OP_SCHEDULE : (r < 77) ? OP_OPEN : (r < 96) ? OP_CLOSE : OP_UNUSED;
      case ($urandom_range(4))
         0:       up = 8'hFF;
         1:       up = 8'(1 << $urandom_range(7));
         2:       up = ~8'(1 << $urandom_range(7));
         default: up = 8'($urandom);
      endcase
      issue(op, 3'($urandom_range(7)), up, 4'($urandom_range(15)));
   endtask

   function automatic logic [7:0] pick_weight();
      case ($urandom_range(9))
         0:             return 8'h00;
         1:             return 8'hFF;
         2, 3, 4, 5, 6: return 8'($urandom_range(1, 3));
         default:       return 8'($urandom);
      endcase
   endfunction

   // Write all six registers with a random setting, extremes included.
   task automatic random_setup(input int block);
      logic [63:0] word;
      logic [3:0]  n;
      word    = {$urandom, $urandom};
      word[0] = (block % 2 == 1) ? MODE_LEAST_CONN : MODE_ROUND_ROBIN;
      set_reg(CSR_POLICY_MODE, word);
      case ($urandom_range(5))
         0:       n = 4'd0;
         1:       n = 4'd1;
         2:       n = 4'd8;
         3:       n = 4'hF;
         default: n = 4'($urandom_range(2, 8));
      endcase
      word      = {$urandom, $urandom};
      word[3:0] = n;
      set_reg(CSR_BACKEND_CNT, word);
      case ($urandom_range(4))
         0:       word = '0;
         1:       word = '1;
         default: begin
            for (int i = 0; i < 8; i++) begin
               word[i*8 +: 8] = pick_weight();
            end
         end
      endcase
      set_reg(CSR_WEIGHTS, word);
      word = {$urandom, $urandom};
      case ($urandom_range(4))
         0:       word[31:0] = '0;
         1:       word[31:0] = '1;
         default: begin
            for (int i = 0; i < 8; i++) begin
               word[i*4 +: 4] = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom);
            end
         end
      endcase
      set_reg(CSR_PRIORITIES, word);
      // Small limits make the connection counts matter.
      for (int r = 0; r < 2; r++) begin
         case ($urandom_range(4))
            0:       word = '0;
            1:       word = '1;
            default: begin
               for (int i = 0; i < 4; i++) begin
                  word[i*16 +: 16] = ($urandom_range(3) == 0) ? 16'($urandom) :
                                                              16'($urandom_range(0, 6));
               end
            end
         endcase
         set_reg((r == 0) ? CSR_LIMITS_LOW : CSR_LIMITS_HIGH, word);
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_POLICY_MODE;
      csr_data  = '0;
      rsp_ready = 1'b0;
      idle_pct  = 0;
      stall_pct = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a single backend, events, a close below zero, the unused opcode.
      issue(OP_SCHEDULE, 3'd0, 8'hFF, 4'd0);
      issue(OP_SCHEDULE, 3'd7, 8'h00, 4'hF);
      issue(OP_OPEN, 3'd0, 8'h00, 4'd0);
      issue(OP_CLOSE, 3'd0, 8'hFF, 4'hF);
      issue(OP_CLOSE, 3'd0, 8'hFF, 4'hF);
      issue(OP_UNUSED, 3'd7, 8'hFF, 4'hF);

      // Eight backends in round robin; backends 1 and 6 have zero weight.
      settle();
      set_reg(CSR_SPARE_LO, {$urandom, $urandom});
      set_reg(CSR_SPARE_HI, '1);
      set_reg(CSR_BACKEND_CNT, 64'd8);
      set_reg(CSR_WEIGHTS, 64'h0300_01FF_0201_0001);
      set_reg(CSR_PRIORITIES, 64'hF000_5000);
      set_reg(CSR_LIMITS_LOW, 64'h0000_0000_0000_0001);
      set_reg(CSR_LIMITS_HIGH, 64'h0000_0000_0000_FFFF);
      set_reg(CSR_POLICY_MODE, 64'(MODE_ROUND_ROBIN));
      repeat (4) issue(OP_SCHEDULE, 3'd0, 8'hFF, 4'hF);
      issue(OP_SCHEDULE, 3'd5, 8'hFF, 4'd0);
      issue(OP_SCHEDULE, 3'd0, 8'h40, 4'hF);
      issue(OP_OPEN, 3'd0, 8'hFF, 4'hF);
      issue(OP_OPEN, 3'd0, 8'hFF, 4'hF);
      issue(OP_SCHEDULE, 3'd0, 8'h01, 4'hF);
      issue(OP_SCHEDULE, 3'd0, 8'h20, 4'hF);

      // The kept position now lies beyond a shrunken backend count.
      settle();
      set_reg(CSR_BACKEND_CNT, 64'd3);
      issue(OP_SCHEDULE, 3'd0, 8'hFF, 4'hF);
      settle();
      set_reg(CSR_BACKEND_CNT, 64'd0);
      issue(OP_SCHEDULE, 3'd0, 8'hFF, 4'hF);

      // Least connections with a count above the number of backends, then one backend.
      settle();
      set_reg(CSR_BACKEND_CNT, 64'hF);
      set_reg(CSR_POLICY_MODE, 64'(MODE_LEAST_CONN));
      issue(OP_SCHEDULE, 3'd0, 8'hFF, 4'hF);
      issue(OP_SCHEDULE, 3'd0, 8'hFE, 4'hF);
      settle();
      set_reg(CSR_BACKEND_CNT, 64'd1);
      issue(OP_SCHEDULE, 3'd0, 8'hFF, 4'hF);
      issue(OP_CLOSE, 3'd0, 8'hFF, 4'hF);
      issue(OP_SCHEDULE, 3'd0, 8'hFF, 4'hF);

      // Drive one connection count up and back down past zero.
      settle();
      set_reg(CSR_BACKEND_CNT, 64'd8);
      set_reg(CSR_WEIGHTS, 64'h0101_0101_0101_0101);
      set_reg(CSR_PRIORITIES, 64'd0);
      set_reg(CSR_LIMITS_LOW, 64'd0);
      set_reg(CSR_LIMITS_HIGH, 64'd0);
      repeat (COUNT_RUN) issue(OP_OPEN, 3'd7, 8'($urandom), 4'($urandom));
      issue(OP_SCHEDULE, 3'd0, 8'hFF, 4'hF);
      issue(OP_SCHEDULE, 3'd0, 8'h80, 4'hF);
      repeat (COUNT_RUN + 4) issue(OP_CLOSE, 3'd7, 8'($urandom), 4'($urandom));

      // Random blocks, each with a fresh setting and one of the idle patterns.
      for (int block = 0; block < RANDOM_BLOCKS; block++) begin
         int pause_at;
         settle();
         random_setup(block);
         case (block % 4)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 66;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 66;
            end
            default: begin
               idle_pct  = 9;
               stall_pct = 9;
            end
         endcase
         pause_at = $urandom_range(BLOCK_ITEMS - 1);
         for (int k = 0; k < BLOCK_ITEMS; k++) begin
            if (k == pause_at) begin
               drain_picks();
            end
            random_item();
         end
      end

      settle();
      if (mismatch_count == 0 && picks_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
